// ===== hw/rtl/qhp_pkg.sv =====
// Package: types and constants for the query-hit payload parser.
package qhp_pkg;

  localparam int MaxPayloadDefault = 65536;
  localparam int HashChars         = 32;
  localparam logic [63:0] DefaultWord = 64'h3030_3030_3030_3030;

  localparam logic [1:0] RecHeader  = 2'd0;
  localparam logic [1:0] RecFile    = 2'd1;
  localparam logic [1:0] RecHash    = 2'd2;
  localparam logic [1:0] RecTrailer = 2'd3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_type;
    logic [7:0]  hit_count;
    logic [15:0] port;
    logic [31:0] ip_address;
    logic [31:0] speed;
    logic [31:0] file_index;
    logic [31:0] file_size;
    logic [15:0] name_length;
    logic [63:0] hash_word;
    logic [1:0]  hash_word_index;
    logic [15:0] ggep_offset;
    logic        last_result;
  } out_item_t;

  function automatic logic [7:0] urn_char(input logic [3:0] idx);
    case (idx)
      4'd0:    urn_char = 8'h75;
      4'd1:    urn_char = 8'h72;
      4'd2:    urn_char = 8'h6e;
      4'd3:    urn_char = 8'h3a;
      4'd4:    urn_char = 8'h73;
      4'd5:    urn_char = 8'h68;
      4'd6:    urn_char = 8'h61;
      4'd7:    urn_char = 8'h31;
      4'd8:    urn_char = 8'h3a;
      default: urn_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== hw/rtl/query_hit_payload_parser.sv =====
// Top level: query-hit payload parser with a result burst buffer.
//
//  channel | signals                      | moves
//  in      | in_valid in_ready in_data    | one payload byte per request
//  out     | out_valid out_ready out_data | one result per request
//
// A byte is parsed in the cycle it is accepted; its results (up to six) are
// held in a result buffer and leave one per cycle while out_ready is high. A
// byte is taken while the buffer drains its last result, so bytes that yield
// at most one result flow one per cycle; a file entry end yields five results.
// rst is synchronous and returns the parser to the header phase.
module query_hit_payload_parser import qhp_pkg::*; #(
  parameter int MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_FIXED, PH_NAME, PH_EXT, PH_TRAILER, PH_OVER
  } phase_t;

  localparam logic [16:0] LastPos = 17'(MAX_PAYLOAD - 1);

  phase_t      phase, phase_next;
  logic [15:0] pos, pos_next;
  logic [7:0]  entries, entries_next;
  logic [31:0] acc, acc_next;
  logic [15:0] held_port, held_port_next;
  logic [31:0] held_address, held_address_next;
  logic [31:0] held_index, held_index_next;
  logic [15:0] name_counter, name_counter_next;
  logic [3:0]  match, match_next;
  logic [63:0] hash_store [4];
  logic [63:0] hash_store_next [4];
  logic [5:0]  hash_count, hash_count_next;
  logic [15:0] trailer_start, trailer_start_next;

  logic [6:0]  pend, pend_next;
  logic [7:0]  ev_hits;
  logic [15:0] ev_port;
  logic [31:0] ev_address, ev_speed, ev_index, ev_size;
  logic [15:0] ev_name, ev_ggep;
  logic [63:0] ev_hash [4];
  logic [63:0] hash_out [4];
  logic [15:0] ggep_next;

  logic        take, give, hash_full;
  logic [7:0]  b;
  logic [1:0]  w;

  assign take = in_valid && in_ready;
  assign give = out_valid && out_ready;
  assign b    = in_data.data_byte;
  assign w    = hash_count[4:3];
  assign hash_full = (hash_count >= 6'(HashChars));

  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    entries_next       = entries;
    acc_next           = acc;
    held_port_next     = held_port;
    held_address_next  = held_address;
    held_index_next    = held_index;
    name_counter_next  = name_counter;
    match_next         = match;
    hash_store_next    = hash_store;
    hash_count_next    = hash_count;
    trailer_start_next = trailer_start;
    pend_next          = 7'd0;
    ggep_next          = 16'd0;
    for (int i = 0; i < 4; i++) begin
      hash_out[i] = hash_full ? hash_store[i] : DefaultWord;
    end
    case (phase)
      PH_HEADER: begin
        if (pos == 16'd0) begin
          entries_next = b;
        end else if (pos == 16'd1) begin
          held_port_next = {8'd0, b};
        end else if (pos == 16'd2) begin
          held_port_next = held_port | {b, 8'd0};
        end else if (pos <= 16'd6) begin
          held_address_next = {held_address[23:0], b};
        end else begin
          acc_next = {b, acc[31:8]};
        end
        if (pos == 16'd10) begin
          pend_next[0]      = 1'b1;
          name_counter_next = 16'd0;
          if (entries_next == 8'd0) begin
            phase_next         = PH_TRAILER;
            trailer_start_next = pos + 16'd1;
            match_next         = 4'd0;
          end else begin
            phase_next = PH_FIXED;
          end
        end
      end
      PH_FIXED: begin
        acc_next = {b, acc[31:8]};
        if (name_counter == 16'd3) begin
          held_index_next = acc_next;
        end
        if (name_counter >= 16'd7) begin
          name_counter_next = 16'd0;
          phase_next        = PH_NAME;
        end else begin
          name_counter_next = name_counter + 16'd1;
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          phase_next      = PH_EXT;
          match_next      = 4'd0;
          hash_count_next = 6'd0;
        end else if (name_counter != 16'hFFFF) begin
          name_counter_next = name_counter + 16'd1;
        end
      end
      PH_EXT: begin
        if (b == 8'd0) begin
          pend_next[5:1]    = 5'b11111;
          for (int i = 0; i < 4; i++) begin
            hash_store_next[i] = DefaultWord;
          end
          hash_count_next   = 6'd0;
          match_next        = 4'd0;
          name_counter_next = 16'd0;
          entries_next      = entries - 8'd1;
          if (entries_next == 8'd0) begin
            phase_next         = PH_TRAILER;
            trailer_start_next = pos + 16'd1;
          end else begin
            phase_next = PH_FIXED;
          end
        end else if (match < 4'd9) begin
          if (b == urn_char(match)) begin
            match_next = match + 4'd1;
          end else begin
            match_next = (b == 8'h75) ? 4'd1 : 4'd0;
          end
        end else if (!hash_full) begin
          hash_store_next[w] = {hash_store[w][55:0], b};
          hash_count_next    = hash_count + 6'd1;
        end
      end
      PH_TRAILER: begin
        if ({1'b0, pos} == {1'b0, trailer_start} + 17'd4) begin
          match_next = {2'b00, match[1], (b == 8'd2)};
        end else if ({1'b0, pos} == {1'b0, trailer_start} + 17'd5) begin
          match_next = {2'b00, b[5], match[0]};
        end
      end
      default: begin
      end
    endcase
    if (in_data.last_byte) begin
      pend_next[6] = 1'b1;
      if (phase_next == PH_TRAILER &&
          {1'b0, in_data.payload_length} > {1'b0, trailer_start_next} + 17'd23 &&
          match_next[1:0] == 2'b11) begin
        ggep_next = trailer_start_next + 16'd7;
      end
      phase_next         = PH_HEADER;
      pos_next           = 16'd0;
      entries_next       = 8'd0;
      acc_next           = 32'd0;
      held_port_next     = 16'd0;
      held_address_next  = 32'd0;
      held_index_next    = 32'd0;
      name_counter_next  = 16'd0;
      match_next         = 4'd0;
      for (int i = 0; i < 4; i++) begin
        hash_store_next[i] = DefaultWord;
      end
      hash_count_next    = 6'd0;
      trailer_start_next = 16'd0;
    end else if (phase_next != PH_OVER) begin
      if ({1'b0, pos} >= LastPos) begin
        phase_next = PH_OVER;
      end else begin
        pos_next = pos + 16'd1;
      end
    end
  end

  assign in_ready  = (pend == 7'd0) || (((pend & (pend - 7'd1)) == 7'd0) && out_ready);
  assign out_valid = (pend != 7'd0);

  always_comb begin
    out_data             = '0;
    out_data.last_result = ((pend & (pend - 7'd1)) == 7'd0);
    if (pend[0]) begin
      out_data.record_type = RecHeader;
      out_data.hit_count   = ev_hits;
      out_data.port        = ev_port;
      out_data.ip_address  = ev_address;
      out_data.speed       = ev_speed;
    end else if (pend[1]) begin
      out_data.record_type = RecFile;
      out_data.file_index  = ev_index;
      out_data.file_size   = ev_size;
      out_data.name_length = ev_name;
    end else if (pend[2]) begin
      out_data.record_type     = RecHash;
      out_data.hash_word       = ev_hash[0];
      out_data.hash_word_index = 2'd0;
    end else if (pend[3]) begin
      out_data.record_type     = RecHash;
      out_data.hash_word       = ev_hash[1];
      out_data.hash_word_index = 2'd1;
    end else if (pend[4]) begin
      out_data.record_type     = RecHash;
      out_data.hash_word       = ev_hash[2];
      out_data.hash_word_index = 2'd2;
    end else if (pend[5]) begin
      out_data.record_type     = RecHash;
      out_data.hash_word       = ev_hash[3];
      out_data.hash_word_index = 2'd3;
    end else begin
      out_data.record_type = RecTrailer;
      out_data.ggep_offset = ev_ggep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      pos           <= 16'd0;
      entries       <= 8'd0;
      acc           <= 32'd0;
      held_port     <= 16'd0;
      held_address  <= 32'd0;
      held_index    <= 32'd0;
      name_counter  <= 16'd0;
      match         <= 4'd0;
      for (int i = 0; i < 4; i++) begin
        hash_store[i] <= DefaultWord;
      end
      hash_count    <= 6'd0;
      trailer_start <= 16'd0;
      pend          <= 7'd0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        pos           <= pos_next;
        entries       <= entries_next;
        acc           <= acc_next;
        held_port     <= held_port_next;
        held_address  <= held_address_next;
        held_index    <= held_index_next;
        name_counter  <= name_counter_next;
        match         <= match_next;
        hash_store    <= hash_store_next;
        hash_count    <= hash_count_next;
        trailer_start <= trailer_start_next;
        pend          <= pend_next;
      end else if (give) begin
        pend <= pend & (pend - 7'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_hits    <= entries;
      ev_port    <= held_port;
      ev_address <= held_address;
      ev_speed   <= {b, acc[31:8]};
      ev_index   <= held_index;
      ev_size    <= acc;
      ev_name    <= name_counter;
      ev_hash    <= hash_out;
      ev_ggep    <= ggep_next;
    end
  end

endmodule
